/* hw/rtl/sird_pkg.sv */
package sird_pkg;

   // Default width of the signed input integer
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RADIX       = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CHARS_LOW   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CHARS_HIGH  = 2'd2;

   localparam int CSR_DATA_WIDTH = 64;
   localparam int RADIX_WIDTH    = 5;
   localparam int DIGIT_WIDTH    = 4;
   localparam int CHAR_WIDTH     = 8;
   localparam int TABLE_WIDTH    = 16 * CHAR_WIDTH;

   // Reset values: radix ten, table "0123456789abcdef"
   localparam logic [RADIX_WIDTH-1:0]    RADIX_RESET = 5'd10;
   localparam logic [CSR_DATA_WIDTH-1:0] LOW_RESET   = 64'h3736_3534_3332_3130;
   localparam logic [CSR_DATA_WIDTH-1:0] HIGH_RESET  = 64'h6665_6463_6261_3938;

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 5'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 5'd16;

   localparam logic [CHAR_WIDTH-1:0] MINUS_CHAR = 8'h2D;

   // Configuration seen by the datapath
   typedef struct packed {
      logic [RADIX_WIDTH-1:0] radix;   // clamped to 2..16
      logic [TABLE_WIDTH-1:0] chars;   // digit value d in bits 8d+7..8d
   } cfg_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic neg;
      logic nib_last;
      logic quot_zero;
      logic ptr_zero;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/sird_if.sv */
// Input channel: one signed integer per transaction
interface sird_req_if
   import sird_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// Result channel: one character per transaction
interface sird_rsp_if
   import sird_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_out;
   logic                  last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink   (input valid, input char_out, input last, output ready);
endinterface

// Configuration write channel
interface sird_csr_if
   import sird_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/sird_regs.sv */
module sird_regs
   import sird_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   logic [RADIX_WIDTH-1:0]    radix_ff, radix_in;
   logic [CSR_DATA_WIDTH-1:0] low_ff, low_in;
   logic [CSR_DATA_WIDTH-1:0] high_ff, high_in;

   // Writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_RADIX:      radix_in = csr_data[RADIX_WIDTH-1:0];
            REG_CHARS_LOW:  low_in   = csr_data;
            REG_CHARS_HIGH: high_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         low_ff   <= LOW_RESET;
         high_ff  <= HIGH_RESET;
      end else begin
         radix_ff <= radix_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   // Out-of-range radix clamps to the nearest legal base
   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         cfg.radix = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         cfg.radix = RADIX_MAX;
      end else begin
         cfg.radix = radix_ff;
      end
      cfg.chars = {high_ff, low_ff};
   end

endmodule

/* hw/rtl/sird_ctrl.sv */
module sird_ctrl
   import sird_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_SIGN  = 3'd2;
   localparam logic [2:0] ST_FETCH = 3'd3;
   localparam logic [2:0] ST_SEND  = 3'd4;

   logic [2:0] state_ff, state_in;

   // Sequencer: divide until the quotient is zero, then send sign and digits
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.nib_last && status.quot_zero) begin
               state_in = status.neg ? ST_SIGN : ST_FETCH;
            end
         end
         ST_SIGN: begin
            if (status.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_SEND;
            end
         end
         // wait state for the registered digit read
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.emit_digit = 1'b1;
               if (status.ptr_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/sird_datapath.sv */
module sird_datapath
   import sird_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  cfg_type                       cfg,
   input  cmd_type                       cmd,
   output status_type                    status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [CHAR_WIDTH-1:0]         rsp_char_out,
   output logic                          rsp_last
);

   localparam int NIBBLES = (VALUE_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int QW      = NIBBLES * DIGIT_WIDTH;
   localparam int NBW     = $clog2(NIBBLES);
   localparam int AW      = $clog2(VALUE_WIDTH);

   // Quotient shift register, partial remainder and counters
   logic [QW-1:0]          mag_ff, mag_in;
   logic [DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [NBW-1:0]         nib_ff, nib_in;
   logic [AW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]          ptr_ff, ptr_in;
   logic                   neg_ff, neg_in;

   // Output register
   logic                   valid_ff, valid_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic                   last_ff, last_in;

   // Digit store, least significant digit at index zero
   logic [DIGIT_WIDTH-1:0] digit_mem [VALUE_WIDTH];
   logic [DIGIT_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]          rd_addr;

   logic [VALUE_WIDTH-1:0] abs_value;
   logic [8:0]             acc;
   logic [8:0]             trial;
   logic [DIGIT_WIDTH-1:0] q;
   logic [QW-1:0]          quot_next;
   logic                   nib_last;
   logic                   out_free;
   logic [CHAR_WIDTH-1:0]  digit_char;

   // Unsigned magnitude; the most negative value maps to 2^(W-1)
   assign abs_value = req_value[VALUE_WIDTH-1] ? (~req_value + VALUE_WIDTH'(1)) : req_value;

   // One quotient nibble per cycle: four compare-subtract steps
   always_comb begin
      acc = {1'b0, rem_ff, mag_ff[QW-1 -: DIGIT_WIDTH]};
      q   = '0;
      for (int b = DIGIT_WIDTH - 1; b >= 0; b--) begin
         trial = 9'(cfg.radix) << b;
         if (acc >= trial) begin
            acc  = acc - trial;
            q[b] = 1'b1;
         end
      end
   end

   assign quot_next  = {mag_ff[QW-DIGIT_WIDTH-1:0], q};
   assign nib_last   = (nib_ff == NBW'(NIBBLES - 1));
   assign out_free   = !valid_ff || rsp_ready;
   assign digit_char = cfg.chars[{rd_data_ff, 3'b000} +: CHAR_WIDTH];
   assign rd_addr    = cmd.emit_digit ? (ptr_ff - AW'(1)) : ptr_ff;

   always_comb begin
      mag_in    = mag_ff;
      rem_in    = rem_ff;
      nib_in    = nib_ff;
      wr_ptr_in = wr_ptr_ff;
      ptr_in    = ptr_ff;
      neg_in    = neg_ff;
      valid_in  = valid_ff && !rsp_ready;
      char_in   = char_ff;
      last_in   = last_ff;

      if (cmd.load) begin
         mag_in    = QW'(abs_value);
         rem_in    = '0;
         nib_in    = '0;
         wr_ptr_in = '0;
         neg_in    = req_value[VALUE_WIDTH-1];
      end

      if (cmd.div_step) begin
         mag_in = quot_next;
         rem_in = acc[DIGIT_WIDTH-1:0];
         nib_in = nib_ff + NBW'(1);
         // digit complete: store it and start the next division
         if (nib_last) begin
            rem_in    = '0;
            nib_in    = '0;
            wr_ptr_in = wr_ptr_ff + AW'(1);
            ptr_in    = wr_ptr_ff;
         end
      end

      if (cmd.emit_sign) begin
         valid_in = 1'b1;
         char_in  = MINUS_CHAR;
         last_in  = 1'b0;
      end

      if (cmd.emit_digit) begin
         valid_in = 1'b1;
         char_in  = digit_char;
         last_in  = (ptr_ff == '0);
         ptr_in   = ptr_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mag_ff    <= mag_in;
      rem_ff    <= rem_in;
      nib_ff    <= nib_in;
      wr_ptr_ff <= wr_ptr_in;
      ptr_ff    <= ptr_in;
      neg_ff    <= neg_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   // Digit memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.div_step && nib_last) begin
         digit_mem[wr_ptr_ff] <= acc[DIGIT_WIDTH-1:0];
      end
      rd_data_ff <= digit_mem[rd_addr];
   end

   assign status.neg       = neg_ff;
   assign status.nib_last  = nib_last;
   assign status.quot_zero = (quot_next == '0);
   assign status.ptr_zero  = (ptr_ff == '0);
   assign status.out_free  = out_free;

   assign rsp_valid    = valid_ff;
   assign rsp_char_out = char_ff;
   assign rsp_last     = last_ff;

endmodule

/* hw/rtl/signed_integer_to_radix_digits.sv */
// Signed integer to radix digit characters.
//
// req_if carries one signed integer per transaction; rsp_if returns its text
// form as a run of 8-bit characters, most significant digit first, with a
// leading '-' for negative values and last set on the final character.
// csr_if writes the radix (index 0, clamped to 2..16) and the two halves of
// the 16-entry character table (indexes 1 and 2); write only while idle.
//
// Each digit is produced by dividing the magnitude by the radix, one quotient
// nibble per cycle. For a negative value the sign leaves during the digit
// read. With the receiver always ready, characters then leave at one per
// cycle. A new integer is accepted once the last character of the previous
// run sits in the output register.
//
// Reset restores radix ten and the table "0123456789abcdef" and empties the
// output register. When the receiver stalls, the current character holds and
// digit emission waits; nothing is dropped.
module signed_integer_to_radix_digits
   import sird_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)(
   input  logic        clock,
   input  logic        reset,
   sird_req_if.sink    req_if,
   sird_rsp_if.source  rsp_if,
   sird_csr_if.sink    csr_if
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   sird_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_if.valid),
      .csr_ready (csr_if.ready),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .cfg       (cfg)
   );

   sird_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sird_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_value    (req_if.value),
      .cfg          (cfg),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_char_out (rsp_if.char_out),
      .rsp_last     (rsp_if.last)
   );

endmodule

/* tb/tb_signed_integer_to_radix_digits.sv */
module tb_signed_integer_to_radix_digits;
   import sird_pkg::*;

   localparam int VW = VALUE_WIDTH_DEFAULT;

   // Index with no register behind it; a write there must change nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED = 2'd3;

   localparam int STALL_LIMIT     = 3000;
   localparam int HOLD_OFF_AT     = 300;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 8;
   localparam int TAIL_CYCLES     = 40;
   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 55;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_out;
      logic                  last;
   } char_beat_type;

   typedef enum {ROW_ITEM, ROW_WRITE} row_kind_type;

   // One directed step: either a register write or an integer with optional typed text
   typedef struct {
      row_kind_type               kind;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
      logic signed [VW-1:0]       value;
      string                      text;
   } step_row_type;

   logic clock;
   logic reset;

   sird_req_if #(.VALUE_WIDTH(VW)) req_bus ();
   sird_rsp_if                     rsp_bus ();
   sird_csr_if                     csr_bus ();

   signed_integer_to_radix_digits #(
      .VALUE_WIDTH (VW)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Own copy of the configuration
   logic [RADIX_WIDTH-1:0] model_radix;
   logic [TABLE_WIDTH-1:0] model_table;

   char_beat_type pending_chars [$];
   step_row_type  directed_steps [$];
   int            mismatch_count;
   int            idle_cycles;
   int            beats_taken;
   bit            send_quiet;
   bit            take_quiet;

   always #6 clock = ~clock;

   // Idle gap per transaction; toggles now and then into a run without gaps
   function automatic int draw_gap(inout bit quiet);
      if ($urandom_range(0, 15) == 0)
         quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   // Expected characters of one integer under the current configuration
   function automatic void predict_digits(input logic signed [VW-1:0] v);
      logic [VW-1:0]          mag;
      logic [VW-1:0]          base;
      logic [DIGIT_WIDTH-1:0] digit_buf [0:VW-1];
      int                     n;
      n = 0;
      if (model_radix < RADIX_MIN)
         base = VW'(RADIX_MIN);
      else if (model_radix > RADIX_MAX)
         base = VW'(RADIX_MAX);
      else
         base = VW'(model_radix);
      mag = v[VW-1] ? (~v + 1'b1) : v;
      // least significant digit first
      do begin
         digit_buf[n] = DIGIT_WIDTH'(mag % base);
         mag = mag / base;
         n++;
      end while (mag != 0);
      if (v[VW-1])
         pending_chars.push_back('{char_out: MINUS_CHAR, last: 1'b0});
      for (int i = n - 1; i >= 0; i--)
         pending_chars.push_back('{char_out: model_table[CHAR_WIDTH*digit_buf[i] +: CHAR_WIDTH],
                                   last: (i == 0)});
   endfunction

   // Offer one integer; expectations are queued at acceptance. Called at a falling edge.
   task automatic push_value(input logic signed [VW-1:0] v, input int gap,
                             input string expected_text);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (expected_text.len() == 0)
         predict_digits(v);
      else
         for (int i = 0; i < expected_text.len(); i++)
            pending_chars.push_back('{char_out: expected_text[i],
                                      last: (i == expected_text.len() - 1)});
      @(negedge clock);
   endtask

   // Register write, only once the block has drained
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      req_bus.valid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (index)
         REG_RADIX:      model_radix = data[RADIX_WIDTH-1:0];
         REG_CHARS_LOW:  model_table[CSR_DATA_WIDTH-1:0] = data;
         REG_CHARS_HIGH: model_table[TABLE_WIDTH-1:CSR_DATA_WIDTH] = data;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Result checker: each accepted character against the oldest expectation
   always @(posedge clock) begin
      char_beat_type exp_beat;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_chars.size() == 0) begin
            $error("unexpected transaction: char_out %h last %b",
                   rsp_bus.char_out, rsp_bus.last);
            mismatch_count++;
         end else begin
            exp_beat = pending_chars.pop_front();
            if (rsp_bus.char_out !== exp_beat.char_out) begin
               $error("char_out: expected %h, actual %h", exp_beat.char_out, rsp_bus.char_out);
               mismatch_count++;
            end
            if (rsp_bus.last !== exp_beat.last) begin
               $error("last: expected %b, actual %b", exp_beat.last, rsp_bus.last);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random ready gaps, one long hold-off to back the block up
   initial begin
      int gap;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap(take_quiet);
         if (beats_taken == HOLD_OFF_AT)
            gap = HOLD_OFF_CYCLES;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         beats_taken++;
         @(negedge clock);
      end
   end

   // Stimulus
   initial begin
      logic signed [VW-1:0]      v;
      logic [RADIX_WIDTH-1:0]    r_pick;
      logic [CSR_DATA_WIDTH-1:0] csr_word;

      clock          = 1'b0;
      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      csr_bus.valid  = 1'b0;
      csr_bus.index  = '0;
      csr_bus.data   = '0;
      model_radix    = RADIX_RESET;
      model_table    = {HIGH_RESET, LOW_RESET};
      mismatch_count = 0;
      idle_cycles    = 0;
      beats_taken    = 0;
      send_quiet     = 1'b0;
      take_quiet     = 1'b0;

      directed_steps = '{
         // reset configuration: radix ten, "0123456789abcdef"
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sd0,           "0"},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sh7FFF_FFFF,   "2147483647"},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sh8000_0000,   "-2147483648"},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  -32'sd1,          "-1"},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sd1,           "1"},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sd12345,       ""},
         // binary: longest runs, then hexadecimal
         '{ROW_WRITE, REG_RADIX,      64'd2,  32'sd0,           ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sh8000_0000,   ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sh7FFF_FFFF,   ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sd0,           "0"},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  -32'sd6,          "-110"},
         '{ROW_WRITE, REG_RADIX,      64'd16, 32'sd0,           ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sh8000_0000,   "-80000000"},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sh7FFF_FFFF,   "7fffffff"},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  -32'sd1,          "-1"},
         // radix out of range clamps to two or sixteen
         '{ROW_WRITE, REG_RADIX,      64'd0,  32'sd0,           ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sd5,           "101"},
         '{ROW_WRITE, REG_RADIX,      64'd1,  32'sd0,           ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  -32'sd5,          "-101"},
         '{ROW_WRITE, REG_RADIX,      64'd31, 32'sd0,           ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sd255,         "ff"},
         '{ROW_WRITE, REG_RADIX,      64'd17, 32'sd0,           ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sd4096,        "1000"},
         // unmapped index leaves everything as it was
         '{ROW_WRITE, REG_UNMAPPED,   '1,     32'sd0,           ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sd171,         "ab"},
         // table extremes
         '{ROW_WRITE, REG_CHARS_LOW,  '1,     32'sd0,           ""},
         '{ROW_WRITE, REG_CHARS_HIGH, '0,     32'sd0,           ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sh89AB_CDEF,   ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  32'sh0123_4567,   ""},
         '{ROW_WRITE, REG_RADIX,      64'd3,  32'sd0,           ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  -32'sd100,        ""},
         // back to reset configuration
         '{ROW_WRITE, REG_RADIX,      64'd10, 32'sd0,           ""},
         '{ROW_WRITE, REG_CHARS_LOW,  LOW_RESET,  32'sd0,       ""},
         '{ROW_WRITE, REG_CHARS_HIGH, HIGH_RESET, 32'sd0,       ""},
         '{ROW_ITEM,  REG_RADIX,      64'd0,  -32'sd2147483647, "-2147483647"}
      };

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == ROW_WRITE)
            write_reg(directed_steps[i].index, directed_steps[i].data);
         else
            push_value(directed_steps[i].value, draw_gap(send_quiet), directed_steps[i].text);
      end

      // random part: new configuration per phase, extremes of radix first
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0)
            r_pick = RADIX_MIN;
         else if (phase == 1)
            r_pick = RADIX_MAX;
         else
            case ($urandom_range(0, 3))
               0:       r_pick = RADIX_WIDTH'($urandom_range(0, 31));
               1:       r_pick = 5'd10;
               default: r_pick = RADIX_WIDTH'($urandom_range(2, 16));
            endcase
         csr_word = {$urandom, $urandom};
         csr_word[RADIX_WIDTH-1:0] = r_pick;
         write_reg(REG_RADIX, csr_word);
         if ($urandom_range(0, 1)) begin
            write_reg(REG_CHARS_LOW, {$urandom, $urandom});
            write_reg(REG_CHARS_HIGH, {$urandom, $urandom});
         end else begin
            write_reg(REG_CHARS_LOW, LOW_RESET);
            write_reg(REG_CHARS_HIGH, HIGH_RESET);
         end
         if ($urandom_range(0, 3) == 0)
            write_reg(REG_UNMAPPED, {$urandom, $urandom});

         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            case ($urandom_range(0, 9))
               0: case ($urandom_range(0, 3))
                     0:       v = 32'sh8000_0000;
                     1:       v = 32'sh7FFF_FFFF;
                     2:       v = '0;
                     default: v = -32'sd1;
                  endcase
               1, 2: begin
                  v = $urandom_range(0, 300);
                  if ($urandom_range(0, 1))
                     v = -v;
               end
               default: v = $urandom;
            endcase
            push_value(v, draw_gap(send_quiet), "");
         end
      end

      // drain, then let the block settle
      req_bus.valid <= 1'b0;
      while (pending_chars.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
